// ----- sv/phx4_pkg.sv -----
// Shared types, constants and helpers of the Philox4x32 random generator.
package phx4_pkg;

    localparam int unsigned ROUND_COUNT = 10;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [2*WORD_W-1:0] prod_t;

    localparam word_t MUL_A  = 32'hD2511F53;
    localparam word_t MUL_B  = 32'hCD9E8D57;
    localparam word_t WEYL_A = 32'h9E3779B9;
    localparam word_t WEYL_B = 32'hBB67AE85;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_WORD0 = 1'b0,
        REG_KEY_WORD1 = 1'b1
    } cfg_reg_t;

    // Four counter/state words of one block.
    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
    } block_t;

    // Key pair used by one round.
    typedef struct packed {
        word_t k0;
        word_t k1;
    } key_t;

    // Offset of the key schedule at a given round: step * round, mod 2^32.
    function automatic word_t weyl_offset(input word_t step, input int unsigned round_idx);
        prod_t prod;
        prod = prod_t'(step) * prod_t'(round_idx);
        return prod[WORD_W-1:0];
    endfunction

endpackage

// ----- sv/philox4x32_10_rng_unit.sv -----
// Top level of the Philox4x32-10 counter-based random generator.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, counter_word0..3      | beat in
//  out     | out_valid, out_ready, random_word0..3     | beat out
//  cfg     | cfg_write, cfg_index, cfg_data            | write only
//
// The pipeline has one register stage per round, each holding one pair of
// 32x32 multipliers. Throughput is one beat per cycle while out_ready is high.
// Reset clears the stage valid bits and both key words; payload is not reset.
// Each stage advances on its own when its output is empty or being taken,
// so bubbles collapse and a stall at the output backs up stage by stage.
// Round keys are derived from the key registers at each stage, so a beat in
// flight picks up a new key in its remaining rounds: write the key only while
// the pipeline is empty.
module philox4x32_10_rng_unit
    import phx4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  word_t                  counter_word0,
    input  word_t                  counter_word1,
    input  word_t                  counter_word2,
    input  word_t                  counter_word3,
    output logic                   out_valid,
    input  logic                   out_ready,
    output word_t                  random_word0,
    output word_t                  random_word1,
    output word_t                  random_word2,
    output word_t                  random_word3,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  word_t                  cfg_data
);

    key_t   key;
    block_t stage_block [ROUND_COUNT+1];
    logic   stage_valid [ROUND_COUNT+1];
    logic   stage_ready [ROUND_COUNT+1];
    key_t   stage_key   [ROUND_COUNT];

    phx4_key_regs u_key_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // Stage zero is the input port itself.
    assign stage_block[0].w0 = counter_word0;
    assign stage_block[0].w1 = counter_word1;
    assign stage_block[0].w2 = counter_word2;
    assign stage_block[0].w3 = counter_word3;
    assign stage_valid[0]    = in_valid;
    assign in_ready          = stage_ready[0];

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        // Key schedule: base key plus r Weyl steps, wrapping at 2^32.
        assign stage_key[r].k0 = key.k0 + weyl_offset(WEYL_A, r);
        assign stage_key[r].k1 = key.k1 + weyl_offset(WEYL_B, r);

        phx4_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[r]),
            .in_ready  (stage_ready[r]),
            .in_block  (stage_block[r]),
            .round_key (stage_key[r]),
            .out_valid (stage_valid[r+1]),
            .out_ready (stage_ready[r+1]),
            .out_block (stage_block[r+1])
        );
    end

    // Last stage register is the output register.
    assign stage_ready[ROUND_COUNT] = out_ready;
    assign out_valid    = stage_valid[ROUND_COUNT];
    assign random_word0 = stage_block[ROUND_COUNT].w0;
    assign random_word1 = stage_block[ROUND_COUNT].w1;
    assign random_word2 = stage_block[ROUND_COUNT].w2;
    assign random_word3 = stage_block[ROUND_COUNT].w3;

endmodule

// ----- sv/phx4_key_regs.sv -----
// Key configuration registers of the Philox4x32 generator.
module phx4_key_regs
    import phx4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  word_t                  cfg_data,
    output key_t                   key
);

    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        key_next = key_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_WORD0: key_next.k0 = cfg_data;
                REG_KEY_WORD1: key_next.k1 = cfg_data;
                default:       key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

// ----- sv/phx4_round.sv -----
// One registered Philox round: two 32x32 products, word shuffle and key mix.
module phx4_round
    import phx4_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  block_t in_block,
    input  key_t   round_key,
    output logic   out_valid,
    input  logic   out_ready,
    output block_t out_block
);

    logic   valid_reg;
    logic   valid_next;
    block_t block_reg;
    block_t block_next;
    prod_t  prod_a;
    prod_t  prod_b;
    logic   load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        prod_a = prod_t'(MUL_A) * prod_t'(in_block.w0);
        prod_b = prod_t'(MUL_B) * prod_t'(in_block.w2);
        block_next.w0 = prod_b[2*WORD_W-1:WORD_W] ^ in_block.w1 ^ round_key.k0;
        block_next.w1 = prod_b[WORD_W-1:0];
        block_next.w2 = prod_a[2*WORD_W-1:WORD_W] ^ in_block.w3 ^ round_key.k1;
        block_next.w3 = prod_a[WORD_W-1:0];
        valid_next    = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds unless a new beat loads.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            block_reg <= block_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;

endmodule
